>>> hw/rtl/tpbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpbp_pkg
// Shared widths, coefficient reset values and the control store of the
// two-pole band-pass sequencer.
// ----------------------------------------------------------------------------
package tpbp_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_FRAC_DEF   = 22;

    localparam int HIST_W  = 32;
    localparam int MUL_B_W = 32;
    localparam int GAIN_Q  = 30;

    localparam int DG_W  = 23;
    localparam int SIG_W = 21;
    localparam int FF_W  = 24;
    localparam int SF_W  = 23;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECT_GAIN       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_INPUT_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_FEEDBACK    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_FEEDBACK   = 2'd3;

    localparam logic        [DG_W-1:0]  DG_RESET  = 23'd3774874;
    localparam logic signed [SIG_W-1:0] SIG_RESET = -21'sd377487;
    localparam logic signed [FF_W-1:0]  FF_RESET  = 24'sd736171;
    localparam logic signed [SF_W-1:0]  SF_RESET  = -23'sd41943;

    // 0.95 in q1.30
    localparam logic signed [MUL_B_W-1:0] GAIN_095 = 32'sd1020054733;

    localparam logic signed [HIST_W-1:0] HIST_MAX = 32'sh7fff_ffff;
    localparam logic signed [HIST_W-1:0] HIST_MIN = 32'sh8000_0000;

    // operand a select
    localparam logic [2:0] A_X  = 3'd0;
    localparam logic [2:0] A_OI = 3'd1;
    localparam logic [2:0] A_PO = 3'd2;
    localparam logic [2:0] A_OO = 3'd3;
    localparam logic [2:0] A_Y  = 3'd4;

    // operand b select
    localparam logic [2:0] B_DG   = 3'd0;
    localparam logic [2:0] B_SIG  = 3'd1;
    localparam logic [2:0] B_FF   = 3'd2;
    localparam logic [2:0] B_SF   = 3'd3;
    localparam logic [2:0] B_GAIN = 3'd4;

    // accumulator operation
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    // step condition
    localparam logic [1:0] COND_NONE = 2'd0;
    localparam logic [1:0] COND_IN   = 2'd1;
    localparam logic [1:0] COND_OUT  = 2'd2;

    localparam int STEP_W = 4;

    typedef struct packed {
        logic [2:0]        a_sel;
        logic [2:0]        b_sel;
        logic              mul_en;
        logic [1:0]        acc_op;
        logic              y_ld;
        logic              hist_ld;
        logic              out_ld;
        logic [1:0]        cond;
        logic [STEP_W-1:0] next_step;
    } ctrl_t;

    function automatic ctrl_t ctrl_rom(input logic [STEP_W-1:0] step);
        ctrl_t cw;
        cw = '{a_sel: A_X, b_sel: B_DG, mul_en: 1'b0, acc_op: ACC_HOLD,
               y_ld: 1'b0, hist_ld: 1'b0, out_ld: 1'b0, cond: COND_NONE,
               next_step: step + 4'd1};
        case (step)
            4'd0:
            begin
                cw.cond = COND_IN;
            end
            4'd1:
            begin
                cw.a_sel  = A_X;
                cw.b_sel  = B_DG;
                cw.mul_en = 1'b1;
            end
            4'd2:
            begin
                cw.acc_op = ACC_LOAD;
                cw.a_sel  = A_OI;
                cw.b_sel  = B_SIG;
                cw.mul_en = 1'b1;
            end
            4'd3:
            begin
                cw.acc_op = ACC_ADD;
                cw.a_sel  = A_PO;
                cw.b_sel  = B_FF;
                cw.mul_en = 1'b1;
            end
            4'd4:
            begin
                cw.acc_op = ACC_ADD;
                cw.a_sel  = A_OO;
                cw.b_sel  = B_SF;
                cw.mul_en = 1'b1;
            end
            4'd5:
            begin
                cw.acc_op = ACC_ADD;
            end
            4'd6:
            begin
                cw.y_ld = 1'b1;
            end
            4'd7:
            begin
                cw.a_sel   = A_Y;
                cw.b_sel   = B_GAIN;
                cw.mul_en  = 1'b1;
                cw.hist_ld = 1'b1;
            end
            4'd8:
            begin
                cw.out_ld    = 1'b1;
                cw.cond      = COND_OUT;
                cw.next_step = 4'd0;
            end
            default:
            begin
                cw.next_step = 4'd0;
            end
        endcase
        return cw;
    endfunction

endpackage

>>> hw/rtl/two_pole_bandpass_iir.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_pole_bandpass_iir
// Two-pole resonator band-pass filter run by a microcoded sequencer over
// one shared multiplier and one accumulator.
// Each input word runs through the nine-step control program on a single
// 32x32 multiplier before the next word is accepted; the program waits at
// its last step while the output register is still full.
// Reset: coefficients return to their defaults, history and output valid cleared.
// A coefficient write also clears the history.
// ----------------------------------------------------------------------------
module two_pole_bandpass_iir #(
    parameter int SAMPLE_BITS    = tpbp_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = tpbp_pkg::COEF_FRAC_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [SAMPLE_BITS-1:0] sample_in, zero padded to bytes
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [SAMPLE_BITS-1:0] sample_out, zero padded to bytes
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tpbp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpbp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int MUL_A_W = tpbp_pkg::HIST_W;
    localparam int PROD_W  = MUL_A_W + tpbp_pkg::MUL_B_W;
    localparam int ACC_W   = PROD_W + 2;

    localparam logic signed [ACC_W-1:0]  ACC_HALF  = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) <<< (tpbp_pkg::GAIN_Q - 1);
    localparam logic signed [ACC_W-1:0]  Y_MAX     = ACC_W'(tpbp_pkg::HIST_MAX);
    localparam logic signed [ACC_W-1:0]  Y_MIN     = ACC_W'(tpbp_pkg::HIST_MIN);
    localparam logic signed [PROD_W-1:0] S_MAX     = (PROD_W'(1) <<< (SAMPLE_BITS - 1))
                                                     - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] S_MIN     = ~S_MAX;

    // coefficients
    logic        [tpbp_pkg::DG_W-1:0]  dg_reg;
    logic signed [tpbp_pkg::SIG_W-1:0] sig_reg;
    logic signed [tpbp_pkg::FF_W-1:0]  ff_reg;
    logic signed [tpbp_pkg::SF_W-1:0]  sf_reg;

    // history
    logic signed [SAMPLE_BITS-1:0]     prev_in_reg;
    logic signed [SAMPLE_BITS-1:0]     older_in_reg;
    logic signed [tpbp_pkg::HIST_W-1:0] prev_out_reg;
    logic signed [tpbp_pkg::HIST_W-1:0] older_out_reg;

    // datapath
    logic signed [SAMPLE_BITS-1:0]      x_reg;
    logic signed [tpbp_pkg::HIST_W-1:0] y_reg;
    logic signed [tpbp_pkg::HIST_W-1:0] y_next;
    logic signed [PROD_W-1:0]           prod_reg;
    logic signed [PROD_W-1:0]           prod_next;
    logic signed [ACC_W-1:0]            acc_reg;
    logic signed [ACC_W-1:0]            acc_next;
    logic signed [ACC_W-1:0]            acc_shr;
    logic signed [PROD_W-1:0]           prod_shr;
    logic signed [MUL_A_W-1:0]          mul_a;
    logic signed [tpbp_pkg::MUL_B_W-1:0] mul_b;
    logic        [SAMPLE_BITS-1:0]      res_next;

    // sequencer
    logic [tpbp_pkg::STEP_W-1:0] step_reg;
    logic [tpbp_pkg::STEP_W-1:0] step_next;
    tpbp_pkg::ctrl_t             cw;
    logic                        advance;
    logic                        in_acc;
    logic                        out_free;
    logic                        cfg_wr;

    // output register
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_data_reg;

    assign cw       = tpbp_pkg::ctrl_rom(step_reg);
    assign s_tready = (cw.cond == tpbp_pkg::COND_IN);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign cfg_wr   = cfg_valid && cfg_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'(out_data_reg);

    always_comb
    begin
        case (cw.cond)
            tpbp_pkg::COND_IN:  advance = in_acc;
            tpbp_pkg::COND_OUT: advance = out_free;
            default:            advance = 1'b1;
        endcase
        step_next = advance ? cw.next_step : step_reg;
    end

    always_comb
    begin
        case (cw.a_sel)
            tpbp_pkg::A_X:  mul_a = MUL_A_W'(x_reg);
            tpbp_pkg::A_OI: mul_a = MUL_A_W'(older_in_reg);
            tpbp_pkg::A_PO: mul_a = prev_out_reg;
            tpbp_pkg::A_OO: mul_a = older_out_reg;
            default:        mul_a = y_reg;
        endcase
        case (cw.b_sel)
            tpbp_pkg::B_DG:  mul_b = tpbp_pkg::MUL_B_W'($signed({1'b0, dg_reg}));
            tpbp_pkg::B_SIG: mul_b = tpbp_pkg::MUL_B_W'(sig_reg);
            tpbp_pkg::B_FF:  mul_b = tpbp_pkg::MUL_B_W'(ff_reg);
            tpbp_pkg::B_SF:  mul_b = tpbp_pkg::MUL_B_W'(sf_reg);
            default:         mul_b = tpbp_pkg::GAIN_095;
        endcase
        prod_next = mul_a * mul_b;
    end

    always_comb
    begin
        case (cw.acc_op)
            tpbp_pkg::ACC_LOAD: acc_next = ACC_W'(prod_reg);
            tpbp_pkg::ACC_ADD:  acc_next = acc_reg + ACC_W'(prod_reg);
            default:            acc_next = acc_reg;
        endcase
    end

    // round half up, then saturate to the history range
    always_comb
    begin
        acc_shr = (acc_reg + ACC_HALF) >>> COEF_FRAC_BITS;
        if (acc_shr > Y_MAX)
            y_next = tpbp_pkg::HIST_MAX;
        else if (acc_shr < Y_MIN)
            y_next = tpbp_pkg::HIST_MIN;
        else
            y_next = acc_shr[tpbp_pkg::HIST_W-1:0];
    end

    // scale by 0.95, round half up, saturate to the sample range
    always_comb
    begin
        prod_shr = (prod_reg + PROD_HALF) >>> tpbp_pkg::GAIN_Q;
        if (prod_shr > S_MAX)
            res_next = S_MAX[SAMPLE_BITS-1:0];
        else if (prod_shr < S_MIN)
            res_next = S_MIN[SAMPLE_BITS-1:0];
        else
            res_next = prod_shr[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (cw.out_ld && advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dg_reg        <= tpbp_pkg::DG_RESET;
            sig_reg       <= tpbp_pkg::SIG_RESET;
            ff_reg        <= tpbp_pkg::FF_RESET;
            sf_reg        <= tpbp_pkg::SF_RESET;
            prev_in_reg   <= '0;
            older_in_reg  <= '0;
            prev_out_reg  <= '0;
            older_out_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                tpbp_pkg::REG_DIRECT_GAIN:
                    dg_reg <= cfg_data[tpbp_pkg::DG_W-1:0];
                tpbp_pkg::REG_SECOND_INPUT_GAIN:
                    sig_reg <= $signed(cfg_data[tpbp_pkg::SIG_W-1:0]);
                tpbp_pkg::REG_FIRST_FEEDBACK:
                    ff_reg <= $signed(cfg_data[tpbp_pkg::FF_W-1:0]);
                tpbp_pkg::REG_SECOND_FEEDBACK:
                    sf_reg <= $signed(cfg_data[tpbp_pkg::SF_W-1:0]);
                default:
                    dg_reg <= dg_reg;
            endcase
            prev_in_reg   <= '0;
            older_in_reg  <= '0;
            prev_out_reg  <= '0;
            older_out_reg <= '0;
        end
        else if (cw.hist_ld)
        begin
            older_in_reg  <= prev_in_reg;
            prev_in_reg   <= x_reg;
            older_out_reg <= prev_out_reg;
            prev_out_reg  <= y_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
            x_reg <= $signed(s_tdata[SAMPLE_BITS-1:0]);
        if (cw.mul_en)
            prod_reg <= prod_next;
        acc_reg <= acc_next;
        if (cw.y_ld)
            y_reg <= y_next;
        if (cw.out_ld && advance)
            out_data_reg <= res_next;
    end

endmodule
